// ===== src/bnms_pkg.sv =====
// Shared types and constants of the box non-maximum suppression block.
// No dependencies; every other file imports this package.
package bnms_pkg;

  localparam int unsigned MAX_KEPT_DEF    = 64;
  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned IOU_W           = 16;
  localparam logic [IOU_W-1:0] IOU_RESET  = 16'd29491;
  localparam int unsigned IDX_W           = 16;
  localparam int unsigned APB_AW          = 3;
  localparam int unsigned APB_DW          = 32;

  typedef enum logic [0:0] {
    REG_IOU_THRESHOLD = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic tail;
  } cell_ctrl_t;

endpackage

// ===== src/bnms_in_if.sv =====
// Input channel of the box non-maximum suppression block: one box per transfer.
// Depends on bnms_pkg for the default coordinate width.
interface bnms_in_if import bnms_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_w;
  logic [COORD_BITS-1:0] box_h;
  logic                  new_set;

  modport source (output valid, box_x, box_y, box_w, box_h, new_set, input ready);
  modport sink   (input valid, box_x, box_y, box_w, box_h, new_set, output ready);
endinterface

// ===== src/bnms_out_if.sv =====
// Result channel of the box non-maximum suppression block: one verdict per transfer.
// Depends on bnms_pkg for the index width.
interface bnms_out_if import bnms_pkg::*;;
  logic             valid;
  logic             ready;
  logic             keep;
  logic [IDX_W-1:0] box_index;
  logic             list_full;

  modport source (output valid, keep, box_index, list_full, input ready);
  modport sink   (input valid, keep, box_index, list_full, output ready);
endinterface

// ===== src/bnms_cell.sv =====
// One cell of the kept-box ring: holds one packed box and its area.
// Depends on bnms_pkg for the cell control struct.
module bnms_cell import bnms_pkg::*; #(
  parameter int unsigned W = 1
) (
  input  logic         clk_i,
  input  cell_ctrl_t   ctrl_i,
  input  logic [W-1:0] load_data_i,
  input  logic [W-1:0] next_data_i,
  input  logic [W-1:0] wrap_data_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] data_q;
  logic [W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = load_data_i;
    end else if (ctrl_i.shift) begin
      data_d = ctrl_i.tail ? wrap_data_i : next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== src/bnms_iou.sv =====
// Five-stage pipelined overlap test of a candidate box against one kept box.
// Depends on bnms_pkg for default widths.
module bnms_iou import bnms_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    issue_i,
  input  logic [COORD_BITS-1:0]   cand_x_i,
  input  logic [COORD_BITS-1:0]   cand_y_i,
  input  logic [COORD_BITS-1:0]   cand_w_i,
  input  logic [COORD_BITS-1:0]   cand_h_i,
  input  logic [2*COORD_BITS-1:0] cand_area_i,
  input  logic [COORD_BITS-1:0]   kept_x_i,
  input  logic [COORD_BITS-1:0]   kept_y_i,
  input  logic [COORD_BITS-1:0]   kept_w_i,
  input  logic [COORD_BITS-1:0]   kept_h_i,
  input  logic [2*COORD_BITS-1:0] kept_area_i,
  input  logic [IOU_W-1:0]        thresh_i,
  output logic                    valid_o,
  output logic                    suppress_o,
  output logic                    busy_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned EW = CW + 1;
  localparam int unsigned AW = 2 * CW;
  localparam int unsigned IW = 2 * EW;
  localparam int unsigned UW = AW + 1;
  localparam int unsigned PW = IW + IOU_W;

  logic [4:0] v_q;

  logic [EW-1:0] c_r, c_b, k_r, k_b, lo_x, lo_y, hi_x, hi_y;
  logic          disjoint;
  logic [EW-1:0] iw_d, ih_d;

  logic [EW-1:0] iw1_q, ih1_q;
  logic [UW-1:0] sum1_q, sum2_q;
  logic [IW-1:0] inter2_q, inter3_q, inter4_q;
  logic [UW-1:0] uni3_q;
  logic          nz4_q;
  logic [PW-1:0] prod4_q;
  logic          sup5_q;

  always_comb begin
    c_r  = EW'(cand_x_i) + EW'(cand_w_i);
    c_b  = EW'(cand_y_i) + EW'(cand_h_i);
    k_r  = EW'(kept_x_i) + EW'(kept_w_i);
    k_b  = EW'(kept_y_i) + EW'(kept_h_i);
    lo_x = (c_r < k_r) ? c_r : k_r;
    lo_y = (c_b < k_b) ? c_b : k_b;
    hi_x = (cand_x_i > kept_x_i) ? EW'(cand_x_i) : EW'(kept_x_i);
    hi_y = (cand_y_i > kept_y_i) ? EW'(cand_y_i) : EW'(kept_y_i);
    disjoint = (EW'(cand_x_i) > k_r) || (c_r < EW'(kept_x_i)) ||
               (EW'(cand_y_i) > k_b) || (c_b < EW'(kept_y_i));
    iw_d = disjoint ? '0 : (lo_x - hi_x);
    ih_d = disjoint ? '0 : (lo_y - hi_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], issue_i};
    end
  end

  always_ff @(posedge clk_i) begin
    iw1_q    <= iw_d;
    ih1_q    <= ih_d;
    sum1_q   <= UW'(cand_area_i) + UW'(kept_area_i);
    inter2_q <= IW'(iw1_q) * IW'(ih1_q);
    sum2_q   <= sum1_q;
    uni3_q   <= UW'(IW'(sum2_q) - inter2_q);
    inter3_q <= inter2_q;
    prod4_q  <= PW'(thresh_i) * PW'(uni3_q);
    nz4_q    <= (uni3_q != '0);
    inter4_q <= inter3_q;
    sup5_q   <= nz4_q && ({inter4_q, {IOU_W{1'b0}}} > prod4_q);
  end

  assign valid_o    = v_q[4];
  assign suppress_o = sup5_q;
  assign busy_o     = |v_q;

endmodule

// ===== src/box_non_max_suppression.sv =====
// Channel    | Dir | Payload
// in_if      | in  | box_x, box_y, box_w, box_h, new_set
// out_if     | out | keep, box_index, list_full
// APB        | in  | iou_threshold at byte address 0
// An item compared with k kept boxes passes through the input transfer, a scan in which the ring
// feeds one kept box per cycle to the overlap pipeline, five pipeline stages, a drain until the
// pipeline is empty and a final state that posts the result; only then is the next box taken in.
// Reset clears the counters and restores the threshold; kept boxes need no clearing.
// A result waits in the output register while the next box is taken in; a stalled
// output holds the block in its final cycle.
// Depends on bnms_pkg, bnms_in_if, bnms_out_if, bnms_cell and bnms_iou.
module box_non_max_suppression import bnms_pkg::*; #(
  parameter int unsigned MAX_KEPT   = MAX_KEPT_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bnms_in_if.sink           in_if,
  bnms_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned AW    = 2 * CW;
  localparam int unsigned BOX_W = 4 * CW + AW;
  localparam int unsigned CNTW  = $clog2(MAX_KEPT + 1);

  state_e state_q, state_d;

  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic [CNTW-1:0]  rem_q, rem_d;
  logic [IDX_W-1:0] set_pos_q, set_pos_d;
  logic [IOU_W-1:0] thresh_q, thresh_d;
  logic [BOX_W-1:0] cand_q;
  logic             sup_q, sup_d;
  logic             out_valid_q, out_valid_d;
  logic             out_keep_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_full_q;

  logic in_xfer, out_free, issue, finish, append, list_full;
  logic cfg_write;
  logic pipe_valid, pipe_sup, pipe_busy;

  logic [BOX_W-1:0] cell_data [MAX_KEPT];
  logic [BOX_W-1:0] head;

  assign in_xfer   = in_if.valid && in_if.ready;
  assign out_free  = !out_valid_q || out_if.ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign head      = cell_data[0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (rem_q == '0 && !pipe_busy) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_if.ready = 1'b0;
    issue       = 1'b0;
    finish      = 1'b0;
    case (state_q)
      ST_IDLE:   in_if.ready = 1'b1;
      ST_SCAN:   issue = (rem_q != '0);
      ST_FINISH: finish = out_free;
      default: begin
        in_if.ready = 1'b0;
      end
    endcase
  end

  assign list_full = (cnt_q >= CNTW'(MAX_KEPT));
  assign append    = finish && !sup_q && !list_full;

  always_comb begin
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    set_pos_d   = set_pos_q;
    sup_d       = sup_q;
    thresh_d    = thresh_q;
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      cnt_d = in_if.new_set ? '0 : cnt_q;
      rem_d = in_if.new_set ? '0 : cnt_q;
      if (in_if.new_set) set_pos_d = '0;
      sup_d = 1'b0;
    end
    if (issue) rem_d = rem_q - CNTW'(1);
    if (pipe_valid && pipe_sup) sup_d = 1'b1;
    if (append) cnt_d = cnt_q + CNTW'(1);
    if (finish && set_pos_q != '1) set_pos_d = set_pos_q + IDX_W'(1);
    if (cfg_write && reg_idx_e'(paddr[2]) == REG_IOU_THRESHOLD) begin
      thresh_d = pwdata[IOU_W-1:0];
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      set_pos_q   <= '0;
      sup_q       <= 1'b0;
      thresh_q    <= IOU_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      set_pos_q   <= set_pos_d;
      sup_q       <= sup_d;
      thresh_q    <= thresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cand_q <= {in_if.box_x, in_if.box_y, in_if.box_w, in_if.box_h,
                 AW'(in_if.box_w) * AW'(in_if.box_h)};
    end
    if (finish) begin
      out_keep_q <= !sup_q;
      out_idx_q  <= set_pos_q;
      out_full_q <= !sup_q && list_full;
    end
  end

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.load  = append && (cnt_q == CNTW'(i));
    assign ctrl.shift = issue;
    assign ctrl.tail  = (cnt_q == CNTW'(i + 1));
    bnms_cell #(
      .W (BOX_W)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .load_data_i (cand_q),
      .next_data_i (cell_data[(i + 1) % MAX_KEPT]),
      .wrap_data_i (head),
      .data_o      (cell_data[i])
    );
  end

  bnms_iou #(
    .COORD_BITS (COORD_BITS)
  ) u_iou (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .cand_x_i    (cand_q[AW+4*CW-1 -: CW]),
    .cand_y_i    (cand_q[AW+3*CW-1 -: CW]),
    .cand_w_i    (cand_q[AW+2*CW-1 -: CW]),
    .cand_h_i    (cand_q[AW+CW-1 -: CW]),
    .cand_area_i (cand_q[AW-1:0]),
    .kept_x_i    (head[AW+4*CW-1 -: CW]),
    .kept_y_i    (head[AW+3*CW-1 -: CW]),
    .kept_w_i    (head[AW+2*CW-1 -: CW]),
    .kept_h_i    (head[AW+CW-1 -: CW]),
    .kept_area_i (head[AW-1:0]),
    .thresh_i    (thresh_q),
    .valid_o     (pipe_valid),
    .suppress_o  (pipe_sup),
    .busy_o      (pipe_busy)
  );

  assign out_if.valid     = out_valid_q;
  assign out_if.keep      = out_keep_q;
  assign out_if.box_index = out_idx_q;
  assign out_if.list_full = out_full_q;

  assign pready = 1'b1;
  assign prdata = (reg_idx_e'(paddr[2]) == REG_IOU_THRESHOLD) ?
                  APB_DW'(thresh_q) : '0;

endmodule

// ===== src/bnms_checker.sv =====
// Port-level assertions for box_non_max_suppression, attached by bind.
// Depends on bnms_pkg for the index width.
module bnms_checker import bnms_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             out_keep_i,
  input logic [IDX_W-1:0] out_box_index_i,
  input logic             out_list_full_i
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before its transfer");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_keep_i) && $stable(out_box_index_i) && $stable(out_list_full_i))
    else $error("result payload changed while stalled");

  // Only a kept box can report a full list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_list_full_i |-> out_keep_i)
    else $error("suppressed box reported with list full");

  // The scan and final states come between, so no new result appears right after an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared one cycle after an input transfer");

endmodule

bind box_non_max_suppression bnms_checker u_bnms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_keep_i      (out_if.keep),
  .out_box_index_i (out_if.box_index),
  .out_list_full_i (out_if.list_full)
);
